// File: rtl/core/iir_velocity_controller_core_defines.svh
// Assertion helpers for the core RTL controller.
`ifndef IIR_VELOCITY_CONTROLLER_CORE_DEFINES_SVH
`define IIR_VELOCITY_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ivc_pkg.sv
`default_nettype none

package ivc_pkg;

    // default filter order; taps above the third are not computed
    localparam int FILTER_ORDER_DEF = 3;
    localparam int MAX_LIVE_TAPS    = 3;
    localparam int TAP_W            = 2;

    // field widths
    localparam int CMD_W   = 3;
    localparam int V_W     = 24;
    localparam int E_W     = 25;
    localparam int Y_W     = 40;
    localparam int COEF_W  = 32;
    localparam int DRIVE_W = 32;
    localparam int OPB_W   = 25;
    localparam int PROD_W  = COEF_W + OPB_W;
    localparam int ACC_W   = 74;

    // fixed-point alignment
    localparam int HI_SHIFT      = 20;
    localparam int Y_RND_SHIFT   = 28;
    localparam int D_RND_SHIFT   = 24;
    localparam int YF_W          = ACC_W - Y_RND_SHIFT;
    localparam int DF_W          = ACC_W - D_RND_SHIFT;
    localparam logic [ACC_W-1:0] Y_RND_INIT = ACC_W'(1) << (Y_RND_SHIFT - 1);
    localparam logic [ACC_W-1:0] D_RND_INIT = ACC_W'(1) << (D_RND_SHIFT - 1);

    // input command codes
    localparam logic [CMD_W-1:0] CMD_MEAS   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TARGET = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

    // register map
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_RESET [0:CFG_NUM-1] = '{
        32'sd260966810,
        -32'sd254894037,
        -32'sd260947574,
        32'sd254913271,
        -32'sd771583239,
        32'sd737898585,
        -32'sd234750800,
        32'sd167772
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FMAC,
        ST_FDRAIN,
        ST_YCHK,
        ST_GMAC,
        ST_GDRAIN,
        ST_DCHK,
        ST_EMIT,
        ST_STOP
    } t_state;

    // product term kinds issued to the shared multiplier
    typedef enum logic [2:0] {
        P_E0,   // b0 * e
        P_BE,   // b[k+1] * e[k]
        P_AYH,  // a[k+1] * y[k] upper part
        P_AYL,  // a[k+1] * y[k] lower 20 bits
        P_GH,   // gain * y upper part
        P_GL    // gain * y lower 20 bits
    } t_part;

    typedef struct packed {
        logic             set_meas;
        logic             set_target;
        logic             clear;
        logic             acc_init_y;
        logic             acc_init_g;
        logic             mul_en;
        t_part            part;
        logic [TAP_W-1:0] tap;
        logic             latch_y;
        logic             latch_drive;
        logic             load_out;
        logic             out_zero;
        logic             commit;
    } t_dp_cmd;

    typedef struct packed {
        logic y_ovf;
        logic fault;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/ivc_datapath.sv
`default_nettype none

module ivc_datapath #(
    parameter int FILTER_ORDER = ivc_pkg::FILTER_ORDER_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ivc_pkg::t_dp_cmd                   i_cmd,
    output ivc_pkg::t_dp_stat                       o_stat,
    input  wire logic [ivc_pkg::V_W-1:0]            i_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [ivc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ivc_pkg::COEF_W-1:0]         i_cfg_data,
    output logic [ivc_pkg::DRIVE_W-1:0]             o_drive,
    output logic                                    o_fault
);

    localparam int USED  = (FILTER_ORDER < ivc_pkg::MAX_LIVE_TAPS) ?
                           FILTER_ORDER : ivc_pkg::MAX_LIVE_TAPS;
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

    localparam int V_W     = ivc_pkg::V_W;
    localparam int E_W     = ivc_pkg::E_W;
    localparam int Y_W     = ivc_pkg::Y_W;
    localparam int OPB_W   = ivc_pkg::OPB_W;
    localparam int PROD_W  = ivc_pkg::PROD_W;
    localparam int ACC_W   = ivc_pkg::ACC_W;
    localparam int LO_W    = ivc_pkg::HI_SHIFT;
    localparam int YF_W    = ivc_pkg::YF_W;
    localparam int DF_W    = ivc_pkg::DF_W;
    localparam int DRIVE_W = ivc_pkg::DRIVE_W;
    localparam int COEF_W  = ivc_pkg::COEF_W;

    logic signed [COEF_W-1:0] r_coef [0:ivc_pkg::CFG_NUM-1];
    logic signed [V_W-1:0]    r_meas;
    logic signed [V_W-1:0]    r_target;
    logic signed [E_W-1:0]    r_err_hist [0:USED-1];
    logic signed [Y_W-1:0]    r_y_hist [0:USED-1];

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_hi;
    logic                     r_prod_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [Y_W-1:0]    r_y;
    logic                     r_y_ovf;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                     r_d_ovf;
    logic [DRIVE_W-1:0]       r_out_drive;
    logic                     r_out_fault;

    logic signed [E_W-1:0]    e_cur;
    logic [IDX_W-1:0]         tap_idx;
    logic [ivc_pkg::CFG_IDX_W-1:0] cidx;
    logic signed [OPB_W-1:0]  opb;
    logic                     op_hi;
    logic                     op_neg;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [YF_W-1:0]   y_full;
    logic signed [YF_W-1:0]   y_chk;
    logic signed [DF_W-1:0]   d_full;
    logic signed [DF_W-1:0]   d_chk;
    logic                     fault;

    // error vanishes while the setpoint is zero
    assign e_cur = (r_target == '0) ? '0 : (E_W'(r_target) - E_W'(r_meas));
    assign tap_idx = i_cmd.tap[IDX_W-1:0];

    always_comb begin
        cidx   = ivc_pkg::REG_B0;
        opb    = '0;
        op_hi  = 1'b0;
        op_neg = 1'b0;
        unique case (i_cmd.part)
            ivc_pkg::P_E0: begin
                cidx = ivc_pkg::REG_B0;
                opb  = e_cur;
            end
            ivc_pkg::P_BE: begin
                cidx = ivc_pkg::REG_B1 + ivc_pkg::CFG_IDX_W'(i_cmd.tap);
                opb  = r_err_hist[tap_idx];
            end
            ivc_pkg::P_AYH: begin
                cidx   = ivc_pkg::REG_A1 + ivc_pkg::CFG_IDX_W'(i_cmd.tap);
                opb    = OPB_W'($signed(r_y_hist[tap_idx][Y_W-1:LO_W]));
                op_hi  = 1'b1;
                op_neg = 1'b1;
            end
            ivc_pkg::P_AYL: begin
                cidx   = ivc_pkg::REG_A1 + ivc_pkg::CFG_IDX_W'(i_cmd.tap);
                opb    = $signed({{(OPB_W-LO_W){1'b0}}, r_y_hist[tap_idx][LO_W-1:0]});
                op_neg = 1'b1;
            end
            ivc_pkg::P_GH: begin
                cidx  = ivc_pkg::REG_GAIN;
                opb   = OPB_W'($signed(r_y[Y_W-1:LO_W]));
                op_hi = 1'b1;
            end
            ivc_pkg::P_GL: begin
                cidx = ivc_pkg::REG_GAIN;
                opb  = $signed({{(OPB_W-LO_W){1'b0}}, r_y[LO_W-1:0]});
            end
            default: begin
                cidx = ivc_pkg::REG_B0;
                opb  = '0;
            end
        endcase
    end

    assign prod     = r_coef[cidx] * opb;
    assign prod_ext = ACC_W'(r_prod);
    assign term     = r_prod_hi ? (prod_ext <<< ivc_pkg::HI_SHIFT) : prod_ext;

    // range checks compare against the sign-extended low part
    assign y_full = r_acc[ACC_W-1:ivc_pkg::Y_RND_SHIFT];
    assign y_chk  = YF_W'($signed(y_full[Y_W-1:0]));
    assign d_full = r_acc[ACC_W-1:ivc_pkg::D_RND_SHIFT];
    assign d_chk  = DF_W'($signed(d_full[DRIVE_W-1:0]));
    assign fault  = r_y_ovf | r_d_ovf;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ivc_pkg::CFG_NUM; i++) begin
                r_coef[i] <= ivc_pkg::COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // samples and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_meas   <= '0;
            r_target <= '0;
            for (int i = 0; i < USED; i++) begin
                r_err_hist[i] <= '0;
                r_y_hist[i]   <= '0;
            end
        end else begin
            if (i_cmd.set_meas) begin
                r_meas <= i_value;
            end
            if (i_cmd.set_target) begin
                r_target <= i_value;
            end
            if (i_cmd.commit) begin
                for (int i = 1; i < USED; i++) begin
                    r_err_hist[i] <= r_err_hist[i-1];
                    r_y_hist[i]   <= r_y_hist[i-1];
                end
                r_err_hist[0] <= e_cur;
                r_y_hist[0]   <= r_y;
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod     <= prod;
            r_prod_hi  <= op_hi;
            r_prod_neg <= op_neg;
        end
    end

    // accumulate, round and range check
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init_y) begin
            r_acc <= ivc_pkg::Y_RND_INIT;
        end else if (i_cmd.acc_init_g) begin
            r_acc <= ivc_pkg::D_RND_INIT;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_neg ? (r_acc - term) : (r_acc + term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_ovf <= 1'b0;
            r_d_ovf <= 1'b0;
        end else begin
            if (i_cmd.latch_y) begin
                r_y_ovf <= (y_full != y_chk);
            end
            if (i_cmd.latch_drive) begin
                r_d_ovf <= (d_full != d_chk);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_y) begin
            r_y <= y_full[Y_W-1:0];
        end
        if (i_cmd.latch_drive) begin
            r_drive <= d_full[DRIVE_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_drive <= (i_cmd.out_zero || fault) ? '0 : r_drive;
            r_out_fault <= !i_cmd.out_zero && fault;
        end
    end

    assign o_stat.y_ovf = r_y_ovf;
    assign o_stat.fault = fault;
    assign o_drive      = r_out_drive;
    assign o_fault      = r_out_fault;

endmodule

`default_nettype wire

// File: rtl/core/ivc_ctrl.sv
`default_nettype none

`include "iir_velocity_controller_core_defines.svh"

module ivc_ctrl #(
    parameter int FILTER_ORDER = ivc_pkg::FILTER_ORDER_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [ivc_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output ivc_pkg::t_dp_cmd                    o_cmd,
    input  wire ivc_pkg::t_dp_stat              i_stat
);

    localparam int USED = (FILTER_ORDER < ivc_pkg::MAX_LIVE_TAPS) ?
                          FILTER_ORDER : ivc_pkg::MAX_LIVE_TAPS;
    localparam logic [ivc_pkg::TAP_W-1:0] LAST_TAP = ivc_pkg::TAP_W'(USED - 1);

    ivc_pkg::t_state            r_state, n_state;
    ivc_pkg::t_part             r_part, n_part;
    logic [ivc_pkg::TAP_W-1:0]  r_tap, n_tap;
    logic                       r_run, n_run;
    logic                       r_out_valid, n_out_valid;
    logic                       accept;
    logic                       slot_free;

    assign o_s_tready = (r_state == ivc_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ivc_pkg::ST_IDLE;
            r_part      <= ivc_pkg::P_E0;
            r_tap       <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_part      <= n_part;
            r_tap       <= n_tap;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and sequencer
    always_comb begin
        n_state = r_state;
        n_part  = r_part;
        n_tap   = r_tap;
        n_run   = r_run;
        unique case (r_state)
            ivc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_s_tuser)
                        ivc_pkg::CMD_TICK: begin
                            if (r_run) begin
                                n_state = ivc_pkg::ST_FMAC;
                                n_part  = ivc_pkg::P_E0;
                                n_tap   = '0;
                            end
                        end
                        ivc_pkg::CMD_START: n_run = 1'b1;
                        ivc_pkg::CMD_STOP:  n_state = ivc_pkg::ST_STOP;
                        default: ;
                    endcase
                end
            end
            ivc_pkg::ST_FMAC: begin
                unique case (r_part)
                    ivc_pkg::P_E0:  n_part = ivc_pkg::P_BE;
                    ivc_pkg::P_BE:  n_part = ivc_pkg::P_AYH;
                    ivc_pkg::P_AYH: n_part = ivc_pkg::P_AYL;
                    ivc_pkg::P_AYL: begin
                        if (r_tap == LAST_TAP) begin
                            n_state = ivc_pkg::ST_FDRAIN;
                        end else begin
                            n_tap  = r_tap + 1'b1;
                            n_part = ivc_pkg::P_BE;
                        end
                    end
                    default: n_state = ivc_pkg::ST_FDRAIN;
                endcase
            end
            ivc_pkg::ST_FDRAIN: n_state = ivc_pkg::ST_YCHK;
            ivc_pkg::ST_YCHK: begin
                n_state = ivc_pkg::ST_GMAC;
                n_part  = ivc_pkg::P_GH;
            end
            ivc_pkg::ST_GMAC: begin
                if (i_stat.y_ovf) begin
                    n_state = ivc_pkg::ST_EMIT;
                end else if (r_part == ivc_pkg::P_GH) begin
                    n_part = ivc_pkg::P_GL;
                end else begin
                    n_state = ivc_pkg::ST_GDRAIN;
                end
            end
            ivc_pkg::ST_GDRAIN: n_state = ivc_pkg::ST_DCHK;
            ivc_pkg::ST_DCHK:   n_state = ivc_pkg::ST_EMIT;
            ivc_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_state = ivc_pkg::ST_IDLE;
                    if (i_stat.fault) begin
                        n_run = 1'b0;
                    end
                end
            end
            ivc_pkg::ST_STOP: begin
                if (slot_free) begin
                    n_state = ivc_pkg::ST_IDLE;
                    n_run   = 1'b0;
                end
            end
            default: n_state = ivc_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.part = r_part;
        o_cmd.tap  = r_tap;
        unique case (r_state)
            ivc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_s_tuser)
                        ivc_pkg::CMD_MEAS:   o_cmd.set_meas   = 1'b1;
                        ivc_pkg::CMD_TARGET: o_cmd.set_target = 1'b1;
                        ivc_pkg::CMD_TICK:   o_cmd.acc_init_y = r_run;
                        ivc_pkg::CMD_START:  o_cmd.clear      = !r_run;
                        default: ;
                    endcase
                end
            end
            ivc_pkg::ST_FMAC: o_cmd.mul_en = 1'b1;
            ivc_pkg::ST_YCHK: begin
                o_cmd.latch_y    = 1'b1;
                o_cmd.acc_init_g = 1'b1;
            end
            ivc_pkg::ST_GMAC: o_cmd.mul_en = !i_stat.y_ovf;
            ivc_pkg::ST_DCHK: o_cmd.latch_drive = 1'b1;
            ivc_pkg::ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.commit   = !i_stat.fault;
                    o_cmd.clear    = i_stat.fault;
                end
            end
            ivc_pkg::ST_STOP: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_zero = 1'b1;
                    o_cmd.clear    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_m_tready);
    assign o_m_tvalid  = r_out_valid;

    `IVC_ASSERT_IMP(a_load_slot_free, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_m_tready, "result loaded over a pending beat")
    `IVC_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, r_out_valid, "loaded result not presented")
    `IVC_ASSERT_NXT(a_fault_halts, i_clk, i_rst_n, o_cmd.load_out && i_stat.fault && !o_cmd.out_zero, !r_run, "fault did not stop the loop")
    `IVC_ASSERT_NXT(a_idle_tick, i_clk, i_rst_n, accept && (i_s_tuser == ivc_pkg::CMD_TICK) && !r_run, r_state == ivc_pkg::ST_IDLE, "tick while stopped started work")

endmodule

`default_nettype wire

// File: rtl/core/iir_velocity_controller_core.sv
// Third-order IIR velocity controller. Input beats carry a command in tuser
// (measured sample, setpoint sample, control tick, start, stop) and a signed
// velocity with 16 fraction bits in tdata. Samples and start produce no
// output. A tick while running produces one output beat, drive = gain * y
// with y = b0*e + b1*e1 + b2*e2 + b3*e3 - a1*y1 - a2*y2 - a3*y3, computed
// on the single shared 32x25 multiplier, which takes one partial product per
// cycle (the 40-bit history values go in as two halves); the gain products
// are skipped when y overflows. Stop clears samples and history and emits a
// zero drive. If y or the drive overflows, the beat carries zero drive with
// the fault flag in tuser and the loop stops until the next start. Coefficients
// are Q3.28 and the gain Q7.24, written through the plain config port; the user
// must write them only while the block is idle, which the block does not
// enforce. The finished beat sits in an output register, so the next command
// is taken while it waits. There is no clearing pass after reset.

`default_nettype none

module iir_velocity_controller_core #(
    parameter int FILTER_ORDER = ivc_pkg::FILTER_ORDER_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [ivc_pkg::V_W-1:0]        i_s_tdata,   // [23:0] value
    input  wire logic [ivc_pkg::CMD_W-1:0]      i_s_tuser,   // [2:0] cmd
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [ivc_pkg::DRIVE_W-1:0]         o_m_tdata,   // [31:0] drive
    output logic [0:0]                          o_m_tuser,   // [0] fault
    input  wire logic                           i_cfg_we,
    input  wire logic [ivc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ivc_pkg::COEF_W-1:0]     i_cfg_data
);

    ivc_pkg::t_dp_cmd  dp_cmd;
    ivc_pkg::t_dp_stat dp_stat;
    logic              out_fault;

    // sequencing, run flag and output handshake
    ivc_ctrl #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // coefficients, history, MAC and output register
    ivc_datapath #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_value    (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_drive    (o_m_tdata),
        .o_fault    (out_fault)
    );

    assign o_m_tuser = out_fault;

endmodule

`default_nettype wire
